// ===== rtl/ntft_pkg.sv =====
// ============================================================================
// ntft_pkg - shared types, constants and functions of the note tuning table
// Beat types for both channels, pipeline stage record, constant generators
// for the equal temperament reset contents and the exp2 root constants.
// ============================================================================
package ntft_pkg;

    localparam int LOG_FRAC = 24;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // register indexes
    localparam logic REG_DETUNE = 1'b0;

    localparam logic [17:0] DETUNE_RESET = 18'd65536;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] note;
        logic        [31:0] entry_frequency;
    } req_t;

    typedef struct packed {
        logic [31:0] tone_frequency;
        logic        clamped_note;
        logic        saturated;
    } rsp_t;

    // one record per pipeline stage; each stage uses the fields it needs
    typedef struct packed {
        logic        direct;
        logic        zero;
        logic        clamp;
        logic [7:0]  frac;
        logic [31:0] ent_a;
        logic [31:0] ya;
        logic [31:0] yb;
        logic [4:0]  ka;
        logic [4:0]  kb;
        logic [23:0] fra;
        logic [23:0] frb;
        logic [28:0] lg;
        logic [31:0] m;
        logic [49:0] prod;
        logic [5:0]  shamt;
        logic [31:0] res;
        logic        sat;
    } pipe_t;

    // position of the leading one, zero for a zero word
    function automatic logic [4:0] msb_index(input logic [31:0] x);
        logic [4:0] k;
        k = '0;
        for (int n = 0; n < 32; n++)
        begin
            if (x[n])
            begin
                k = 5'(n);
            end
        end
        return k;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bp;
        v   = val;
        res = '0;
        bp  = 64'd1 << 62;
        for (int n = 0; n < 32; n++)
        begin
            if (bp > v)
            begin
                bp = bp >> 2;
            end
        end
        for (int n = 0; n < 32; n++)
        begin
            if (bp != 0)
            begin
                if (v >= res + bp)
                begin
                    v   = v - (res + bp);
                    res = (res >> 1) + bp;
                end
                else
                begin
                    res = res >> 1;
                end
                bp = bp >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-i) in Q1.30
    function automatic logic [31:0] root_val(input int i);
        logic [63:0] rt;
        rt = 64'd1 << 31;
        for (int j = 1; j <= i; j++)
        begin
            rt = isqrt64(rt << 30);
        end
        return rt[31:0];
    endfunction

    function automatic logic [63:0] exp2_const(input logic [23:0] r);
        logic [63:0] rt;
        logic [63:0] m;
        rt = 64'd1 << 31;
        m  = 64'd1 << 30;
        for (int i = 1; i <= LOG_FRAC; i++)
        begin
            rt = isqrt64(rt << 30);
            if (r[LOG_FRAC - i])
            begin
                m = (m * rt + (64'd1 << 29)) >> 30;
            end
        end
        return m;
    endfunction

    // equal temperament entry, A4 (note 69) at 440 Hz
    function automatic logic [31:0] reset_entry(input int i, input int ffb);
        int          d;
        int          oct;
        int          s;
        int          sh;
        logic [63:0] rr;
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] r;
        d = i - 69;
        if (d >= 0)
        begin
            oct = d / 12;
        end
        else
        begin
            oct = -((-d + 11) / 12);
        end
        s  = d - 12 * oct;
        rr = (64'(s) * (64'd1 << LOG_FRAC) + 64'd6) / 64'd12;
        m  = exp2_const(rr[23:0]);
        v  = (64'd440 << ffb) * m;
        sh = 30 - oct;
        if (sh <= 0)
        begin
            return '1;
        end
        r = (v + (64'd1 << (sh - 1))) >> sh;
        if (r > 64'hFFFF_FFFF)
        begin
            return '1;
        end
        return r[31:0];
    endfunction

endpackage

// ===== rtl/note_to_frequency_tuning_table.sv =====
// ============================================================================
// note_to_frequency_tuning_table - note table with detuned lookup
// Keeps a table of note frequencies, stores write beats and returns the
// detuned, geometrically interpolated frequency for lookup beats.
// ============================================================================
// Throughput: one beat per cycle while rsp_stall is low; the squaring and root
//   multiplier chains are fully pipelined, so a beat enters every cycle unless stalled.
// Writes give no result and take effect for the very next beat.
// Reset: rst_n clears all valid flags, the detune ratio to 1.0 and the
//   table to equal temperament at once (per-entry valid bits, no sweep).
module note_to_frequency_tuning_table
    import ntft_pkg::*;
#(
    parameter int NOTE_COUNT     = 128,
    parameter int FREQ_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDXW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NOTE_COUNT - 1);
    localparam logic [31:0] MAX_Q = 32'((NOTE_COUNT - 1) * 256);

    // stage map: 0 table read, 1 normalise, squaring chain, blend,
    // root multiplier chain, product, round and saturate
    localparam int ST_NORM  = 1;
    localparam int ST_SQ0   = 2;
    localparam int ST_BLEND = ST_SQ0 + LOG_FRAC;
    localparam int ST_MUL   = ST_BLEND + LOG_FRAC + 1;
    localparam int LAST     = ST_MUL + 1;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [17:0] ratio_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DETUNE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= DETUNE_RESET;
        end
        else if (cfg_wr)
        begin
            ratio_reg <= pwdata[17:0];
        end
    end

    assign prdata = (paddr[2] == REG_DETUNE) ? {14'd0, ratio_reg} : 32'd0;

    // ------------------------------------------------------------------
    // handshake: each stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic [LAST:0]   v_reg;
    logic [LAST+1:0] stage_rdy;
    logic            accept;

    assign stage_rdy[LAST+1] = !rsp_stall;
    for (genvar s = 0; s <= LAST; s++)
    begin : g_rdy
        assign stage_rdy[s] = !v_reg[s] || stage_rdy[s+1];
    end

    assign req_stall = !stage_rdy[0];
    assign accept    = req_valid && stage_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                // write beats never enter the pipeline
                v_reg[0] <= req_valid && (req.cmd == CMD_LOOKUP);
            end
            for (int s = 1; s <= LAST; s++)
            begin
                if (stage_rdy[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // decode the incoming note
    // ------------------------------------------------------------------
    logic [7:0]      note_int;
    logic            lk_clamp;
    logic            wr_en;
    logic [IDXW-1:0] idx;
    logic [IDXW-1:0] addr_a;
    logic [IDXW-1:0] addr_b;

    always_comb
    begin
        note_int = req.note[15:8];
        idx      = IDXW'(note_int);
        lk_clamp = req.note[15] || ({16'd0, req.note} > MAX_Q);
        wr_en    = accept && (req.cmd == CMD_WRITE) && !req.note[15]
                   && (32'(note_int) < 32'(NOTE_COUNT));
        // clamped lookups read the last entry
        if (lk_clamp)
        begin
            addr_a = LAST_IDX;
            addr_b = LAST_IDX;
        end
        else
        begin
            addr_a = idx;
            addr_b = (idx == LAST_IDX) ? idx : idx + IDXW'(1);
        end
    end

    // ------------------------------------------------------------------
    // table memory, valid bits and reset contents
    // ------------------------------------------------------------------
    logic [31:0]           note_mem [NOTE_COUNT];
    logic [NOTE_COUNT-1:0] ent_vld_reg;
    logic [31:0]           rst_tab [NOTE_COUNT];
    logic [31:0]           rd_a_reg;
    logic [31:0]           rd_b_reg;
    logic                  va_reg;
    logic                  vb_reg;
    logic [IDXW-1:0]       addr_a_reg;
    logic [IDXW-1:0]       addr_b_reg;

    for (genvar i = 0; i < NOTE_COUNT; i++)
    begin : g_rst_tab
        localparam logic [31:0] RST_VAL = reset_entry(i, FREQ_FRAC_BITS);
        assign rst_tab[i] = RST_VAL;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            note_mem[idx] <= req.entry_frequency;
        end
        if (accept)
        begin
            rd_a_reg   <= note_mem[addr_a];
            rd_b_reg   <= note_mem[addr_b];
            va_reg     <= ent_vld_reg[addr_a];
            vb_reg     <= ent_vld_reg[addr_b];
            addr_a_reg <= addr_a;
            addr_b_reg <= addr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            ent_vld_reg[idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // pipeline stages
    // ------------------------------------------------------------------
    pipe_t pipe_reg [LAST+1];
    pipe_t pipe_next0;

    always_comb
    begin
        pipe_next0        = '0;
        pipe_next0.clamp  = lk_clamp;
        pipe_next0.frac   = lk_clamp ? 8'd0 : req.note[7:0];
        pipe_next0.direct = lk_clamp || (req.note[7:0] == 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            pipe_reg[0] <= pipe_next0;
        end
    end

    for (genvar s = 1; s <= LAST; s++)
    begin : g_stage
        pipe_t pipe_next;

        if (s == ST_NORM)
        begin : g_norm
            // pick stored or reset contents, then normalise for the log
            logic [31:0] a;
            logic [31:0] b;
            logic [4:0]  ka;
            logic [4:0]  kb;
            always_comb
            begin
                pipe_next       = pipe_reg[s-1];
                a               = va_reg ? rd_a_reg : rst_tab[addr_a_reg];
                b               = vb_reg ? rd_b_reg : rst_tab[addr_b_reg];
                ka              = msb_index(a);
                kb              = msb_index(b);
                pipe_next.ent_a = a;
                pipe_next.zero  = (a == 32'd0) || (b == 32'd0);
                pipe_next.ka    = ka;
                pipe_next.kb    = kb;
                pipe_next.ya    = a << (5'd31 - ka);
                pipe_next.yb    = b << (5'd31 - kb);
                pipe_next.fra   = '0;
                pipe_next.frb   = '0;
            end
        end
        else if (s < ST_BLEND)
        begin : g_square
            // one log fraction bit per lane: square, renormalise
            logic [63:0] pa;
            logic [63:0] pb;
            always_comb
            begin
                pipe_next = pipe_reg[s-1];
                pa = {32'd0, pipe_reg[s-1].ya} * {32'd0, pipe_reg[s-1].ya};
                pb = {32'd0, pipe_reg[s-1].yb} * {32'd0, pipe_reg[s-1].yb};
                if (pa[63])
                begin
                    pipe_next.ya  = pa[63:32];
                    pipe_next.fra = {pipe_reg[s-1].fra[22:0], 1'b1};
                end
                else
                begin
                    pipe_next.ya  = pa[62:31];
                    pipe_next.fra = {pipe_reg[s-1].fra[22:0], 1'b0};
                end
                if (pb[63])
                begin
                    pipe_next.yb  = pb[63:32];
                    pipe_next.frb = {pipe_reg[s-1].frb[22:0], 1'b1};
                end
                else
                begin
                    pipe_next.yb  = pb[62:31];
                    pipe_next.frb = {pipe_reg[s-1].frb[22:0], 1'b0};
                end
            end
        end
        else if (s == ST_BLEND)
        begin : g_blend
            logic [8:0]  w1;
            logic [37:0] acc;
            always_comb
            begin
                pipe_next = pipe_reg[s-1];
                w1  = 9'd256 - {1'b0, pipe_reg[s-1].frac};
                acc = 38'({pipe_reg[s-1].ka, pipe_reg[s-1].fra}) * 38'(w1)
                    + 38'({pipe_reg[s-1].kb, pipe_reg[s-1].frb})
                      * 38'(pipe_reg[s-1].frac)
                    + 38'd128;
                pipe_next.lg = acc[36:8];
                pipe_next.m  = 32'h4000_0000;
            end
        end
        else if (s < ST_MUL)
        begin : g_root
            // fold in 2^(2^-i) when fraction bit i of the log is set
            localparam int          STEP = s - ST_BLEND;
            localparam logic [31:0] ROOT = root_val(STEP);
            logic [63:0] pm;
            always_comb
            begin
                pipe_next = pipe_reg[s-1];
                pm = {32'd0, pipe_reg[s-1].m} * {32'd0, ROOT} + (64'd1 << 29);
                if (pipe_reg[s-1].lg[LOG_FRAC - STEP])
                begin
                    pipe_next.m = pm[61:30];
                end
            end
        end
        else if (s == ST_MUL)
        begin : g_mul
            logic [31:0] opnd;
            always_comb
            begin
                pipe_next = pipe_reg[s-1];
                opnd = pipe_reg[s-1].direct ? pipe_reg[s-1].ent_a : pipe_reg[s-1].m;
                pipe_next.prod  = 50'(opnd) * 50'(ratio_reg);
                pipe_next.shamt = pipe_reg[s-1].direct
                                  ? 6'd16
                                  : 6'd46 - {1'b0, pipe_reg[s-1].lg[28:24]};
            end
        end
        else
        begin : g_round
            // round half up, saturate to 32 bits, zero neighbour gives zero when interpolating
            logic [50:0] sum;
            logic [50:0] shifted;
            always_comb
            begin
                pipe_next = pipe_reg[s-1];
                sum       = {1'b0, pipe_reg[s-1].prod}
                            + (51'd1 << (pipe_reg[s-1].shamt - 6'd1));
                shifted   = sum >> pipe_reg[s-1].shamt;
                if (pipe_reg[s-1].zero && !pipe_reg[s-1].direct)
                begin
                    pipe_next.res = 32'd0;
                    pipe_next.sat = 1'b0;
                end
                else if (|shifted[50:32])
                begin
                    pipe_next.res = 32'hFFFF_FFFF;
                    pipe_next.sat = 1'b1;
                end
                else
                begin
                    pipe_next.res = shifted[31:0];
                    pipe_next.sat = 1'b0;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_rdy[s])
            begin
                pipe_reg[s] <= pipe_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------
    assign rsp_valid          = v_reg[LAST];
    assign rsp.tone_frequency = pipe_reg[LAST].res;
    assign rsp.clamped_note   = pipe_reg[LAST].clamp;
    assign rsp.saturated      = pipe_reg[LAST].sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_stall |-> !req_stall)
        else $error("request stalled while result side is free");

    a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.cmd == CMD_LOOKUP) |=> v_reg[0])
        else $error("accepted lookup lost at table read");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.cmd == CMD_WRITE) |=> !v_reg[0])
        else $error("write beat entered the pipeline");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.saturated |-> (rsp.tone_frequency == 32'hFFFF_FFFF))
        else $error("saturation flag without clamped value");

endmodule

// ===== tb/note_to_frequency_tuning_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_to_frequency_tuning_table_test - self-checking bench for the note table
// Drives write and lookup beats with random gaps and receiver stalls, and
// programs several detune ratios through the register port between phases.
// A scoreboard class keeps its own table and ratio, predicts every lookup and
// compares each result beat field by field.
// ----------------------------------------------------------------------------
module note_to_frequency_tuning_table_test
    import ntft_pkg::*;
();

    localparam int          NOTES        = 128;
    localparam int          FRAC_LOG     = 24;
    localparam int          DRAIN_CYCLES = 60;      // a little over the pipeline latency
    localparam int          HOLD_CYCLES  = 1500;    // long receiver hold-off
    localparam int          CYCLE_LIMIT  = 900000;
    localparam logic [2:0]  ADDR_DETUNE  = 3'(REG_DETUNE) << 2;
    localparam logic [2:0]  ADDR_SPARE   = 3'd4;    // no register behind it

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the table and ratio, queue of pending tones
    // ------------------------------------------------------------------
    class tuning_scoreboard;
        bit [31:0] freq_table [NOTES];
        bit [17:0] ratio;
        bit [63:0] roots [FRAC_LOG + 1];
        rsp_t      pending_tones [$];
        int        errors;

        function bit [63:0] int_sqrt(bit [63:0] val);
            bit [63:0] v;
            bit [63:0] res;
            bit [63:0] bp;
            v   = val;
            res = 0;
            bp  = 64'd1 << 62;
            while (bp > v)
                bp = bp >> 2;
            while (bp != 0)
            begin
                if (v >= res + bp)
                begin
                    v   = v - (res + bp);
                    res = (res >> 1) + bp;
                end
                else
                    res = res >> 1;
                bp = bp >> 2;
            end
            return res;
        endfunction

        function bit [63:0] pow2_frac(bit [63:0] r);
            bit [63:0] m;
            m = 64'd1 << 30;
            for (int i = 1; i <= FRAC_LOG; i++)
                if (r[FRAC_LOG - i])
                    m = (m * roots[i] + (64'd1 << 29)) >> 30;
            return m;
        endfunction

        function bit [63:0] log2_fixed(bit [31:0] x);
            int        k;
            bit [63:0] y;
            bit [63:0] fr;
            k  = 31;
            fr = 0;
            while (k > 0 && !x[k])
                k--;
            y = {32'd0, x} << (31 - k);
            for (int i = 0; i < FRAC_LOG; i++)
            begin
                y  = (y * y) >> 31;
                fr = fr << 1;
                if (y >= (64'd1 << 32))
                begin
                    y     = y >> 1;
                    fr[0] = 1'b1;
                end
            end
            return (64'(k) << FRAC_LOG) | fr;
        endfunction

        function bit [31:0] round_clip(bit [63:0] v, int sh, output bit sat);
            bit [63:0] r;
            r   = (v + (64'd1 << (sh - 1))) >> sh;
            sat = (r > 64'hFFFF_FFFF);
            return sat ? 32'hFFFF_FFFF : r[31:0];
        endfunction

        function new();
            int        d;
            int        oct;
            int        s;
            bit        dummy;
            bit [63:0] m;
            roots[0] = 64'd1 << 31;
            for (int i = 1; i <= FRAC_LOG; i++)
                roots[i] = int_sqrt(roots[i - 1] << 30);
            ratio  = 18'd65536;
            errors = 0;
            for (int i = 0; i < NOTES; i++)
            begin
                d   = i - 69;
                oct = (d >= 0) ? d / 12 : -((-d + 11) / 12);
                s   = d - 12 * oct;
                m   = pow2_frac((64'(s) * (64'd1 << FRAC_LOG) + 64'd6) / 64'd12);
                freq_table[i] = round_clip((64'd440 << 16) * m, 30 - oct, dummy);
            end
        endfunction

        function void note_input(req_t b);
            int        q;
            int        idx;
            int        k;
            bit [63:0] f;
            bit [63:0] l;
            rsp_t      t;
            q = int'(b.note);
            if (b.cmd == CMD_WRITE)
            begin
                if (q >= 0 && (q >>> 8) < NOTES)
                    freq_table[q >>> 8] = b.entry_frequency;
                return;
            end
            t = '0;
            if (q < 0 || q > ((NOTES - 1) << 8))
            begin
                t.clamped_note   = 1'b1;
                t.tone_frequency = round_clip(64'(freq_table[NOTES - 1]) * ratio, 16,
                                              t.saturated);
            end
            else
            begin
                idx = q >>> 8;
                f   = 64'(q & 255);
                if (f == 0)
                    t.tone_frequency = round_clip(64'(freq_table[idx]) * ratio, 16,
                                                  t.saturated);
                else if (freq_table[idx] != 0 && freq_table[idx + 1] != 0)
                begin
                    l = (log2_fixed(freq_table[idx]) * (256 - f)
                         + log2_fixed(freq_table[idx + 1]) * f + 128) >> 8;
                    k = int'(l >> FRAC_LOG);
                    t.tone_frequency = round_clip(pow2_frac(l & 64'hFF_FFFF) * ratio,
                                                  46 - k, t.saturated);
                end
                // a zero neighbour leaves the tone at zero
            end
            pending_tones.push_back(t);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_tones.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: tone %h clamp %b sat %b",
                             got.tone_frequency, got.clamped_note, got.saturated);
                return;
            end
            want = pending_tones.pop_front();
            if (got.tone_frequency != want.tone_frequency
                || got.clamped_note != want.clamped_note
                || got.saturated != want.saturated)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: tone %h/%h clamp %b/%b sat %b/%b (exp/act)",
                             want.tone_frequency, got.tone_frequency, want.clamped_note,
                             got.clamped_note, want.saturated, got.saturated);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tuning_scoreboard tones;
    bit               idle_on;     // random gaps on both sides when set
    bit               hold_req;    // ask the receiver for a long hold-off
    int               cycles;

    note_to_frequency_tuning_table dut (.*);

    // Clock and a watchdog on the cycle count
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: sample result beats at the rising edge, decide the stall
    // at the falling edge. A hold-off request is counted out here.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                tones.check_result(rsp);
                stall_left = idle_on ? $urandom_range(0, 16) : 0;
            end
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall = 1'b1;
            end
            else
                rsp_stall = 1'b0;
        end
    end

    // Offer one beat after a random gap; hold it until the block takes it
    task automatic send_beat(req_t b);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req       = b;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        tones.note_input(b);
    endtask

    task automatic send_lookup(logic [15:0] note);
        req_t b;
        b                 = '0;
        b.cmd             = CMD_LOOKUP;
        b.note            = note;
        b.entry_frequency = $urandom;
        send_beat(b);
    endtask

    task automatic send_write(logic [15:0] note, logic [31:0] freq);
        req_t b;
        b.cmd             = CMD_WRITE;
        b.note            = note;
        b.entry_frequency = freq;
        send_beat(b);
    endtask

    // Register access: setup cycle, then access cycle until pready
    task automatic reg_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write the detune ratio, read it back, mirror it in the scoreboard
    task automatic set_detune(logic [17:0] value);
        logic [31:0] rd;
        reg_access(1'b1, ADDR_DETUNE, {$urandom} << 18 | 32'(value), rd);
        tones.ratio = value;
        reg_access(1'b0, ADDR_DETUNE, '0, rd);
        if (rd[17:0] != value)
        begin
            tones.errors++;
            if (tones.errors <= 10)
                $display("detune readback: expected %h, got %h", value, rd[17:0]);
        end
    endtask

    // Drop valid, let every pending tone arrive, then allow for writes
    // still in flight
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (tones.pending_tones.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly in-range lookups with random fractions, some table writes,
    // and a share of raw 16-bit notes so every note bit toggles
    task automatic send_random_beat();
        int          pick;
        logic [15:0] note;
        logic [31:0] freq;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15)
            note = 16'($urandom);
        else
            note = 16'($urandom_range(0, (NOTES - 1) * 256));
        if (pick < 22)
        begin
            case ($urandom_range(0, 9))
                0:       freq = '0;
                1, 2:    freq = $urandom;
                default: freq = $urandom >> $urandom_range(4, 14);
            endcase
            send_write(note, freq);
        end
        else
            send_lookup(note);
    endtask

    initial
    begin
        logic [31:0] rd;
        logic [17:0] phase_ratio [5];
        tones     = new();
        cycles    = 0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset tuning, range edges, zero neighbours, ignored writes
        send_lookup(16'(69 << 8));
        send_lookup(16'h0000);
        send_lookup(16'(127 << 8));
        send_lookup(16'h8000);
        send_lookup(16'hFFFF);
        send_lookup(16'(127 << 8 | 1));
        send_lookup(16'h7FFF);
        send_lookup(16'(60 << 8 | 128));
        send_lookup(16'h0001);
        send_lookup(16'(126 << 8 | 255));
        send_write(16'(10 << 8), 32'h0);
        send_lookup(16'(10 << 8 | 64));
        send_lookup(16'(9 << 8 | 200));
        send_lookup(16'(10 << 8));
        send_write(16'(128 << 8), 32'h5);
        send_write(16'hFF00, 32'h7);
        send_write(16'(20 << 8 | 8'h7F), 32'hFFFF_FFFF);
        send_lookup(16'(20 << 8));
        send_lookup(16'(19 << 8 | 128));
        send_write(16'(127 << 8), 32'hFFFF_FFFF);
        send_lookup(16'h7FFF);
        drain();

        // A write to an empty address must leave the ratio alone
        reg_access(1'b1, ADDR_SPARE, 32'h0000_1234, rd);
        set_detune(18'h3FFFF);
        send_lookup(16'h7FFF);
        send_lookup(16'(127 << 8));
        send_lookup(16'(126 << 8 | 1));

        phase_ratio[0] = 18'h3FFFF;
        phase_ratio[1] = 18'h0;
        phase_ratio[2] = 18'd65536;
        phase_ratio[3] = 18'($urandom);
        phase_ratio[4] = 18'($urandom);
        for (int p = 0; p < 5; p++)
        begin
            drain();
            set_detune(phase_ratio[p]);
            idle_on = (p != 1);
            if (p == 2)
                hold_req = 1'b1;    // fill the pipe while the receiver holds off
            repeat (375) send_random_beat();
        end

        @(negedge clk);
        req_valid = 1'b0;
        idle_on   = 1'b1;
        drain();
        if (tones.errors == 0 && tones.pending_tones.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== note_to_frequency_tuning_table.f =====
rtl/ntft_pkg.sv
rtl/note_to_frequency_tuning_table.sv
tb/note_to_frequency_tuning_table_test.sv
